/* rtl/watch_time_set_keypad_controller_assert.svh */
// assertion macros for the watch time set keypad controller
`ifndef WATCH_TIME_SET_KEYPAD_CONTROLLER_ASSERT_SVH
`define WATCH_TIME_SET_KEYPAD_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define WTSK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wtsk assertion failed");

// next-cycle implication
`define WTSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wtsk assertion failed");

`endif

/* rtl/wtsk_pkg.sv */
// shared types, constants and digit clamp for the keypad controller
`default_nettype none

package wtsk_pkg;

   localparam logic [7:0] DIGIT_ZERO = 8'd48;
   localparam logic [7:0] DIGIT_NINE = 8'd57;

   localparam logic [7:0] RESET_KEY_DEFAULT      = 8'd70;
   localparam logic [7:0] SET_CANCEL_KEY_DEFAULT = 8'd69;

   typedef enum logic [1:0] {
      CSR_HOUR_FORMAT  = 2'd0,
      CSR_RESET_KEY    = 2'd1,
      CSR_SET_KEY      = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_STANDBY = 1'b0,
      MODE_SETTING = 1'b1
   } mode_type;

   typedef struct packed {
      logic       hour_format_12;
      logic [7:0] reset_key_code;
      logic [7:0] set_cancel_key_code;
   } cfg_type;

   // first member sits in the highest bits, so in_set_mode lands at bit 0
   typedef struct packed {
      logic        key_ignored;
      logic        clock_reset;
      logic [11:0] new_time_hhmm;
      logic        time_commit;
      logic [11:0] partial_time;
      logic [1:0]  digits_held;
      logic        in_set_mode;
   } rsp_type;

   function automatic logic [3:0] clamp_digit(
      input logic [3:0]  d,
      input logic [1:0]  count,
      input logic [11:0] partial,
      input logic        twelve
   );
      logic [3:0] r;
      r = d;
      unique case (count)
         2'd0: begin
            if (twelve) begin
               r = (d > 4'd1) ? 4'd1 : d;
            end else begin
               r = (d > 4'd2) ? 4'd2 : d;
            end
         end
         2'd1: begin
            if (twelve) begin
               if (partial == 12'd0) begin
                  r = (d < 4'd1) ? 4'd1 : d;
               end else begin
                  r = (d > 4'd2) ? 4'd2 : d;
               end
            end else if (partial == 12'd2) begin
               r = (d > 4'd3) ? 4'd3 : d;
            end
         end
         2'd2: begin
            r = (d > 4'd5) ? 4'd5 : d;
         end
         default: begin
            r = d;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/wtsk_csr.sv */
// configuration registers of the keypad controller
`default_nettype none

module wtsk_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   output wtsk_pkg::cfg_type      cfg
);

   wtsk_pkg::cfg_type cfg_ff;
   wtsk_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            wtsk_pkg::CSR_HOUR_FORMAT: cfg_in.hour_format_12      = csr_wdata[0];
            wtsk_pkg::CSR_RESET_KEY:   cfg_in.reset_key_code      = csr_wdata;
            wtsk_pkg::CSR_SET_KEY:     cfg_in.set_cancel_key_code = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hour_format_12      <= 1'b0;
         cfg_ff.reset_key_code      <= wtsk_pkg::RESET_KEY_DEFAULT;
         cfg_ff.set_cancel_key_code <= wtsk_pkg::SET_CANCEL_KEY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/wtsk_engine.sv */
// entry state machine: mode, digit count, partial value, pending reset
`default_nettype none

module wtsk_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        key,
   input  wire wtsk_pkg::cfg_type cfg,
   output wtsk_pkg::rsp_type      result,
   output wtsk_pkg::mode_type     mode,
   output logic [1:0]             count
);

   wtsk_pkg::mode_type mode_ff, mode_in;
   logic [1:0]         count_ff, count_in;
   logic [11:0]        partial_ff, partial_in;
   logic               pending_ff, pending_in;

   logic        is_reset_key;
   logic        is_set_key;
   logic        is_digit;
   logic [7:0]  key_off;
   logic [3:0]  digit_val;
   logic [14:0] times_ten;
   logic [11:0] value_v;
   logic        last_digit;

   assign is_reset_key = (key == cfg.reset_key_code);
   assign is_set_key   = (key == cfg.set_cancel_key_code);
   assign is_digit     = (key >= wtsk_pkg::DIGIT_ZERO) && (key <= wtsk_pkg::DIGIT_NINE);
   assign key_off      = key - wtsk_pkg::DIGIT_ZERO;
   assign digit_val    = wtsk_pkg::clamp_digit(key_off[3:0], count_ff, partial_ff,
                                               cfg.hour_format_12);
   assign times_ten    = {partial_ff, 3'b000} + {2'b00, partial_ff, 1'b0};
   assign value_v      = times_ten[11:0] + {8'd0, digit_val};
   assign last_digit   = (count_ff == 2'd3);

   // next state
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      pending_in = pending_ff;
      priority if (is_reset_key) begin
         pending_in = (mode_ff == wtsk_pkg::MODE_SETTING);
      end else if (is_set_key) begin
         count_in   = 2'd0;
         partial_in = 12'd0;
         if (mode_ff == wtsk_pkg::MODE_SETTING) begin
            mode_in    = wtsk_pkg::MODE_STANDBY;
            pending_in = 1'b0;
         end else begin
            mode_in = wtsk_pkg::MODE_SETTING;
         end
      end else if (is_digit && (mode_ff == wtsk_pkg::MODE_SETTING)) begin
         if (last_digit) begin
            mode_in    = wtsk_pkg::MODE_STANDBY;
            count_in   = 2'd0;
            partial_in = 12'd0;
            pending_in = 1'b0;
         end else begin
            count_in   = count_ff + 2'd1;
            partial_in = value_v;
         end
      end else begin
         mode_in = mode_ff;
      end
   end

   // result fields
   always_comb begin
      result               = '0;
      result.in_set_mode   = (mode_in == wtsk_pkg::MODE_SETTING);
      result.digits_held   = count_in;
      result.partial_time  = partial_in;
      priority if (is_reset_key) begin
         result.clock_reset = (mode_ff == wtsk_pkg::MODE_STANDBY);
      end else if (is_set_key) begin
         result.clock_reset = (mode_ff == wtsk_pkg::MODE_SETTING) && pending_ff;
      end else if (is_digit && (mode_ff == wtsk_pkg::MODE_SETTING)) begin
         result.time_commit   = last_digit;
         result.new_time_hhmm = last_digit ? value_v : 12'd0;
         result.clock_reset   = last_digit && pending_ff;
      end else begin
         result.key_ignored = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= wtsk_pkg::MODE_STANDBY;
         count_ff   <= 2'd0;
         partial_ff <= 12'd0;
         pending_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

   assign mode  = mode_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

/* rtl/watch_time_set_keypad_controller.sv */
// top level of the watch time set keypad controller
//
//   group   dir   handshake          payload
//   req_    in    tvalid / tready    tdata[7:0] key_code
//   rsp_    out   tvalid / tready    tdata[31:0] result fields
//   csr_    in    we                 index[1:0], wdata[7:0]
//
// one item per cycle while rsp_ is not stalled; an item taken on req_ reaches rsp_
// through the input register, then state update and result register
// synchronous active-high reset clears mode, count, value and pending reset
// a stalled result holds in the result register; req_ keeps flowing while
// the input register can drain into it
`default_nettype none
`include "watch_time_set_keypad_controller_assert.svh"

module watch_time_set_keypad_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] key_code
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] in_set_mode, [2:1] digits_held, [14:3] partial_time, [15] time_commit,
   // [27:16] new_time_hhmm, [28] clock_reset, [29] key_ignored, [31:30] zero
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   wtsk_pkg::cfg_type  cfg;
   wtsk_pkg::rsp_type  step_rsp;
   wtsk_pkg::mode_type mode;
   logic [1:0]         count;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        key_ff;
   logic              out_valid_ff, out_valid_in;
   wtsk_pkg::rsp_type out_ff;
   logic              advance;
   logic              req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   wtsk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wtsk_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .key     (key_ff),
      .cfg     (cfg),
      .result  (step_rsp),
      .mode    (mode),
      .count   (count)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   `WTSK_ASSERT_IMPLY(a_standby_no_digits, clock, reset,
      mode == wtsk_pkg::MODE_STANDBY, count == 2'd0)
   `WTSK_ASSERT_IMPLY(a_commit_leaves_setting, clock, reset,
      out_valid_ff && out_ff.time_commit,
      !out_ff.in_set_mode && (out_ff.digits_held == 2'd0))
   `WTSK_ASSERT_IMPLY(a_reset_only_in_standby, clock, reset,
      out_valid_ff && out_ff.clock_reset, !out_ff.in_set_mode)
   `WTSK_ASSERT_NEXT(a_step_fills_output, clock, reset,
      advance, out_valid_ff)

endmodule

`default_nettype wire

/* tb/watch_time_set_keypad_controller_test.sv */
// self-checking testbench for the watch time set keypad controller
`timescale 1ns / 100ps

module watch_time_set_keypad_controller_test;

   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int PHASE_COUNT     = 10;
   localparam int ITEMS_PER_PHASE = 125;

   localparam logic [7:0] DIRECTED_24H [25] = '{
      8'd0, 8'd255, 8'd53, 8'd70, 8'd69, 8'd57, 8'd57, 8'd57, 8'd57,
      8'd69, 8'd70, 8'd48, 8'd57, 8'd55, 8'd49, 8'd69, 8'd49, 8'd50,
      8'd69, 8'd69, 8'd70, 8'd69, 8'd47, 8'd58, 8'd48
   };
   localparam logic [7:0] DIRECTED_12H [10] = '{
      8'd69, 8'd57, 8'd57, 8'd57, 8'd57, 8'd69, 8'd48, 8'd48, 8'd48, 8'd48
   };

   class time_entry_scoreboard;
      wtsk_pkg::cfg_type  cfg;
      wtsk_pkg::mode_type mode;
      logic [1:0]         count;
      logic [11:0]        value;
      logic               pending;
      wtsk_pkg::rsp_type  expected_results[$];
      int                 failures;

      function new();
         cfg.hour_format_12      = 1'b0;
         cfg.reset_key_code      = wtsk_pkg::RESET_KEY_DEFAULT;
         cfg.set_cancel_key_code = wtsk_pkg::SET_CANCEL_KEY_DEFAULT;
         mode     = wtsk_pkg::MODE_STANDBY;
         count    = 2'd0;
         value    = 12'd0;
         pending  = 1'b0;
         failures = 0;
      endfunction

      function void set_register(wtsk_pkg::csr_index_type idx, logic [7:0] data);
         case (idx)
            wtsk_pkg::CSR_HOUR_FORMAT: cfg.hour_format_12      = data[0];
            wtsk_pkg::CSR_RESET_KEY:   cfg.reset_key_code      = data;
            wtsk_pkg::CSR_SET_KEY:     cfg.set_cancel_key_code = data;
            default: ;
         endcase
      endfunction

      function logic [3:0] limit_digit(logic [3:0] d);
         logic [3:0] top;
         case (count)
            2'd0: begin
               top = cfg.hour_format_12 ? 4'd1 : 4'd2;
               return (d > top) ? top : d;
            end
            2'd1: begin
               if (cfg.hour_format_12) begin
                  if (value == 12'd0) return (d == 4'd0) ? 4'd1 : d;
                  return (d > 4'd2) ? 4'd2 : d;
               end
               if (value == 12'd2) return (d > 4'd3) ? 4'd3 : d;
               return d;
            end
            2'd2: return (d > 4'd5) ? 4'd5 : d;
            default: return d;
         endcase
      endfunction

      function wtsk_pkg::rsp_type predict_result(logic [7:0] key);
         wtsk_pkg::rsp_type r;
         logic [7:0]        offset;
         logic [11:0]       v;
         r = '0;
         if (key == cfg.reset_key_code) begin
            if (mode == wtsk_pkg::MODE_SETTING) begin
               pending = 1'b1;
            end else begin
               r.clock_reset = 1'b1;
               pending = 1'b0;
            end
         end else if (key == cfg.set_cancel_key_code) begin
            count = 2'd0;
            value = 12'd0;
            if (mode == wtsk_pkg::MODE_SETTING) begin
               mode = wtsk_pkg::MODE_STANDBY;
               if (pending) begin
                  r.clock_reset = 1'b1;
                  pending = 1'b0;
               end
            end else begin
               mode = wtsk_pkg::MODE_SETTING;
            end
         end else if (key >= wtsk_pkg::DIGIT_ZERO && key <= wtsk_pkg::DIGIT_NINE) begin
            if (mode == wtsk_pkg::MODE_SETTING) begin
               offset = key - wtsk_pkg::DIGIT_ZERO;
               v = value * 12'd10 + {8'd0, limit_digit(offset[3:0])};
               if (count == 2'd3) begin
                  r.time_commit   = 1'b1;
                  r.new_time_hhmm = v;
                  mode  = wtsk_pkg::MODE_STANDBY;
                  count = 2'd0;
                  value = 12'd0;
                  if (pending) begin
                     r.clock_reset = 1'b1;
                     pending = 1'b0;
                  end
               end else begin
                  value = v;
                  count = count + 2'd1;
               end
            end else begin
               r.key_ignored = 1'b1;
            end
         end else begin
            r.key_ignored = 1'b1;
         end
         r.in_set_mode  = mode;
         r.digits_held  = count;
         r.partial_time = value;
         return r;
      endfunction

      function void note_key(logic [7:0] key);
         expected_results.push_back(predict_result(key));
      endfunction

      function void check_result(logic [31:0] data);
         wtsk_pkg::rsp_type e, a;
         a = wtsk_pkg::rsp_type'(data[29:0]);
         if (expected_results.size() == 0) begin
            $error("result with no item waiting: %h", data);
            failures++;
            return;
         end
         e = expected_results.pop_front();
         if (data[31:30] !== 2'b00) begin
            $error("pad expected 0 actual %0d", data[31:30]);
            failures++;
         end
         if (a.in_set_mode !== e.in_set_mode) begin
            $error("in_set_mode expected %0d actual %0d", e.in_set_mode, a.in_set_mode);
            failures++;
         end
         if (a.digits_held !== e.digits_held) begin
            $error("digits_held expected %0d actual %0d", e.digits_held, a.digits_held);
            failures++;
         end
         if (a.partial_time !== e.partial_time) begin
            $error("partial_time expected %0d actual %0d", e.partial_time, a.partial_time);
            failures++;
         end
         if (a.time_commit !== e.time_commit) begin
            $error("time_commit expected %0d actual %0d", e.time_commit, a.time_commit);
            failures++;
         end
         if (a.new_time_hhmm !== e.new_time_hhmm) begin
            $error("new_time_hhmm expected %0d actual %0d", e.new_time_hhmm,
                   a.new_time_hhmm);
            failures++;
         end
         if (a.clock_reset !== e.clock_reset) begin
            $error("clock_reset expected %0d actual %0d", e.clock_reset, a.clock_reset);
            failures++;
         end
         if (a.key_ignored !== e.key_ignored) begin
            $error("key_ignored expected %0d actual %0d", e.key_ignored, a.key_ignored);
            failures++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] key_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] in_set_mode, [2:1] digits_held, [14:3] partial_time, [15] time_commit,
   // [27:16] new_time_hhmm, [28] clock_reset, [29] key_ignored
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = 2'd0;
   logic [7:0]  csr_wdata  = 8'd0;

   time_entry_scoreboard time_board = new();
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_left  = 0;
   int phase_sent  = 0;
   int cycle_count = 0;

   watch_time_set_keypad_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready = 1'b1;
         1: rsp_tready = 1'($urandom_range(0, 1));
         2: rsp_tready = ($urandom_range(0, 3) != 0);
         default: rsp_tready = (stall_left % 5 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) time_board.check_result(rsp_tdata);
   end

   task automatic send_key(input logic [7:0] key);
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = key;
      do @(posedge clock); while (!req_tready);
      time_board.note_key(key);
      phase_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            req_tdata  = 8'($urandom_range(0, 255));
         end
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (time_board.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input wtsk_pkg::csr_index_type idx,
                                 input logic [7:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      time_board.set_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [7:0] pick_key_code();
      case ($urandom_range(0, 6))
         0: return wtsk_pkg::RESET_KEY_DEFAULT;
         1: return wtsk_pkg::SET_CANCEL_KEY_DEFAULT;
         2: return 8'($urandom_range(0, 255));
         3: return 8'($urandom_range(48, 57));
         4: return 8'h00;
         5: return 8'hFF;
         default: return $urandom_range(0, 1) ? 8'd47 : 8'd58;
      endcase
   endfunction

   // set key, some digits with an occasional reset key, maybe a cancel
   task automatic send_time_entry();
      int digits;
      digits = $urandom_range(0, 4);
      send_key(time_board.cfg.set_cancel_key_code);
      for (int i = 0; i < digits; i++) begin
         if ($urandom_range(0, 9) == 0) send_key(time_board.cfg.reset_key_code);
         send_key(8'($urandom_range(48, 57)));
      end
      if (digits < 4 && $urandom_range(0, 1)) send_key(time_board.cfg.set_cancel_key_code);
   endtask

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watch_time_set_keypad_controller_test failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_24H[i]) send_key(DIRECTED_24H[i]);
      wait_for_results();
      write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'd1);
      foreach (DIRECTED_12H[i]) send_key(DIRECTED_12H[i]);
      wait_for_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'd1);
               write_register(wtsk_pkg::CSR_RESET_KEY, 8'h00);
               write_register(wtsk_pkg::CSR_SET_KEY, 8'hFF);
            end
            1: begin
               write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'd0);
               write_register(wtsk_pkg::CSR_RESET_KEY, 8'hFF);
               write_register(wtsk_pkg::CSR_SET_KEY, 8'h00);
            end
            2: begin
               // shared code: reset role wins
               write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'($urandom_range(0, 1)));
               write_register(wtsk_pkg::CSR_RESET_KEY, 8'd53);
               write_register(wtsk_pkg::CSR_SET_KEY, 8'd53);
            end
            3: begin
               write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'd0);
               write_register(wtsk_pkg::CSR_RESET_KEY, wtsk_pkg::RESET_KEY_DEFAULT);
               write_register(wtsk_pkg::CSR_SET_KEY, wtsk_pkg::SET_CANCEL_KEY_DEFAULT);
            end
            default: begin
               write_register(wtsk_pkg::CSR_HOUR_FORMAT, 8'($urandom_range(0, 255)));
               write_register(wtsk_pkg::CSR_RESET_KEY, pick_key_code());
               write_register(wtsk_pkg::CSR_SET_KEY, pick_key_code());
            end
         endcase
         phase_sent = 0;
         while (phase_sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 4) != 0) begin
               send_time_entry();
            end else begin
               repeat ($urandom_range(1, 3)) send_key(8'($urandom_range(0, 255)));
            end
         end
         wait_for_results();
      end

      repeat (8) @(posedge clock);
      if (time_board.failures == 0 && time_board.expected_results.size() == 0) begin
         $display("watch_time_set_keypad_controller_test passed");
      end else begin
         $display("watch_time_set_keypad_controller_test failed");
      end
      $finish;
   end

endmodule

/* watch_time_set_keypad_controller.f */
+incdir+rtl
rtl/wtsk_pkg.sv
rtl/wtsk_csr.sv
rtl/wtsk_engine.sv
rtl/watch_time_set_keypad_controller.sv
tb/watch_time_set_keypad_controller_test.sv
